// ===== hdl/imhs_pkg.sv =====
// Shared types and codes for the indexed min-heap task scheduler.
// No dependencies; used by indexed_min_heap_task_scheduler_unit.
package imhs_pkg;

    localparam int TASK_IDS = 16;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_CHANGE = 2'd2;
    localparam logic [1:0] OP_NOP    = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_PRESENT = 2'd2;
    localparam logic [1:0] ST_ABSENT  = 2'd3;

    typedef struct packed {
        logic [1:0] opcode;
        logic [3:0] task_id;
        logic [7:0] priority_req;
    } in_item_t;

    typedef struct packed {
        logic [3:0] top_task;
        logic [7:0] top_priority;
        logic [4:0] entry_count;
        logic       heap_empty;
        logic [1:0] status;
    } out_item_t;

    // One heap slot: the task and its priority kept side by side.
    typedef struct packed {
        logic [3:0] task_id;
        logic [7:0] prio;
    } heap_entry_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_POS,
        S_ENT,
        S_UP,
        S_UP_CMP,
        S_RM_RD,
        S_RM_LD,
        S_DN,
        S_DN_L,
        S_DN_R,
        S_DN_DEC,
        S_FIN,
        S_FIN2
    } fsm_state_t;

endpackage

// ===== hdl/indexed_min_heap_task_scheduler_unit.sv =====
// Indexed binary min-heap task scheduler, top level.
// Depends on imhs_pkg for payload types, codes and FSM states.
//
// s_valid/s_ready/s_data carry one request (opcode, task_id, priority_req);
// m_valid/m_ready/m_data return one result per request: root task and its
// priority, entry count, empty flag and status. A transfer happens on a
// rising aclk edge with valid and ready both high.
// heap_mem holds {task, priority} per slot, pos_mem the slot of each task;
// both read registered, one read and one write per cycle.
// One request at a time. A refused request or a no-op goes straight to the
// result; insert climbs level by level from the new last slot, change looks
// up the position and then the entry and sifts up or down, remove looks both
// up, forces the entry to the root, then moves the last entry there and
// sifts it down (or ends at once when it empties the heap). s_ready is high
// only when idle, so the next input transfer waits until the result is posted.
// Reset (aresetn low, synchronous): heap empty, no task present, no result
// pending, s_ready low. Memory contents are not cleared.
// Stall: a result waits in the output register until m_ready; the next
// request is still taken and worked on, and its result holds in the final
// state until the output register frees.
module indexed_min_heap_task_scheduler_unit #(
    parameter int TASK_SLOTS = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  imhs_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output imhs_pkg::out_item_t m_data
);

    localparam int SW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
    localparam int CW = $clog2(TASK_SLOTS + 1);
    localparam int XW = SW + 2;   // child index, may run past the heap

    // Storage
    imhs_pkg::heap_entry_t heap_mem [TASK_SLOTS];
    logic [SW-1:0]         pos_mem  [imhs_pkg::TASK_IDS];

    // Control registers
    imhs_pkg::fsm_state_t state_reg, state_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [15:0]          present_reg, present_next;
    logic                 m_valid_reg, m_valid_next;

    // Working registers
    imhs_pkg::in_item_t    req_reg, req_next;
    imhs_pkg::heap_entry_t cur_reg, cur_next;    // entry being moved
    imhs_pkg::heap_entry_t best_reg, best_next;  // best of moving entry and children on sift-down
    logic [SW-1:0]         s_reg, s_next;        // current hole slot
    logic [SW-1:0]         bidx_reg, bidx_next;
    logic                  bwin_reg, bwin_next;
    logic                  force_reg, force_next;
    logic [1:0]            stat_reg, stat_next;
    imhs_pkg::out_item_t   m_data_reg, m_data_next;

    // Memory ports
    logic                  heap_re, heap_we, pos_we;
    logic [SW-1:0]         heap_raddr, heap_waddr, pos_wdata;
    logic [3:0]            pos_waddr;
    imhs_pkg::heap_entry_t heap_wdata, heap_rd_reg;
    logic [SW-1:0]         pos_rd_reg;
    logic                  pos_re;

    // Tree arithmetic
    logic [SW-1:0] parent_idx;
    logic [XW-1:0] left_x, right_x, n_x;

    assign parent_idx = SW'((s_reg - SW'(1)) >> 1);
    assign left_x     = XW'({s_reg, 1'b1});
    assign right_x    = left_x + XW'(1);
    assign n_x        = XW'(count_reg);

    assign s_ready = aresetn && (state_reg == imhs_pkg::S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (heap_we) begin
            heap_mem[heap_waddr] <= heap_wdata;
        end
        if (heap_re) begin
            heap_rd_reg <= heap_mem[heap_raddr];
        end
        if (pos_we) begin
            pos_mem[pos_waddr] <= pos_wdata;
        end
        if (pos_re) begin
            pos_rd_reg <= pos_mem[s_data.task_id];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= imhs_pkg::S_IDLE;
            count_reg   <= '0;
            present_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            present_reg <= present_next;
            m_valid_reg <= m_valid_next;
        end
        req_reg    <= req_next;
        cur_reg    <= cur_next;
        best_reg   <= best_next;
        s_reg      <= s_next;
        bidx_reg   <= bidx_next;
        bwin_reg   <= bwin_next;
        force_reg  <= force_next;
        stat_reg   <= stat_next;
        m_data_reg <= m_data_next;
    end

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        present_next = present_reg;
        m_valid_next = m_valid_reg && !m_ready;
        req_next     = req_reg;
        cur_next     = cur_reg;
        best_next    = best_reg;
        s_next       = s_reg;
        bidx_next    = bidx_reg;
        bwin_next    = bwin_reg;
        force_next   = force_reg;
        stat_next    = stat_reg;
        m_data_next  = m_data_reg;
        heap_re      = 1'b0;
        heap_raddr   = '0;
        heap_we      = 1'b0;
        heap_waddr   = s_reg;
        heap_wdata   = cur_reg;
        pos_re       = 1'b0;
        pos_we       = 1'b0;
        pos_waddr    = cur_reg.task_id;
        pos_wdata    = s_reg;

        unique case (state_reg)
            imhs_pkg::S_IDLE: begin
                pos_re = s_valid;
                if (s_valid) begin
                    req_next   = s_data;
                    stat_next  = imhs_pkg::ST_OK;
                    force_next = 1'b0;
                    state_next = imhs_pkg::S_FIN;
                    case (s_data.opcode) inside
                        imhs_pkg::OP_INSERT: begin
                            if (present_reg[s_data.task_id]) begin
                                stat_next = imhs_pkg::ST_PRESENT;
                            end else if (count_reg >= CW'(TASK_SLOTS)) begin
                                stat_next = imhs_pkg::ST_FULL;
                            end else begin
                                cur_next = '{task_id: s_data.task_id,
                                             prio: s_data.priority_req};
                                s_next   = count_reg[SW-1:0];
                                count_next = count_reg + CW'(1);
                                present_next[s_data.task_id] = 1'b1;
                                state_next = imhs_pkg::S_UP;
                            end
                        end
                        imhs_pkg::OP_REMOVE, imhs_pkg::OP_CHANGE: begin
                            if (!present_reg[s_data.task_id]) begin
                                stat_next = imhs_pkg::ST_ABSENT;
                            end else begin
                                state_next = imhs_pkg::S_POS;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            imhs_pkg::S_POS: begin
                s_next     = pos_rd_reg;
                heap_re    = 1'b1;
                heap_raddr = pos_rd_reg;
                state_next = imhs_pkg::S_ENT;
            end
            imhs_pkg::S_ENT: begin
                cur_next = heap_rd_reg;
                if (req_reg.opcode == imhs_pkg::OP_REMOVE) begin
                    force_next = 1'b1;
                    state_next = imhs_pkg::S_UP;
                end else begin
                    cur_next.prio = req_reg.priority_req;
                    if (req_reg.priority_req < heap_rd_reg.prio) begin
                        state_next = imhs_pkg::S_UP;
                    end else begin
                        state_next = imhs_pkg::S_DN;
                    end
                end
            end
            imhs_pkg::S_UP: begin
                if (s_reg == '0) begin
                    heap_we = 1'b1;
                    pos_we  = 1'b1;
                    state_next = force_reg ? imhs_pkg::S_RM_RD : imhs_pkg::S_FIN;
                end else begin
                    heap_re    = 1'b1;
                    heap_raddr = parent_idx;
                    state_next = imhs_pkg::S_UP_CMP;
                end
            end
            imhs_pkg::S_UP_CMP: begin
                heap_we = 1'b1;
                pos_we  = 1'b1;
                if (force_reg || (heap_rd_reg.prio > cur_reg.prio)) begin
                    // parent moves down into the hole
                    heap_wdata = heap_rd_reg;
                    pos_waddr  = heap_rd_reg.task_id;
                    s_next     = parent_idx;
                    state_next = imhs_pkg::S_UP;
                end else begin
                    state_next = imhs_pkg::S_FIN;
                end
            end
            imhs_pkg::S_RM_RD: begin
                count_next = count_reg - CW'(1);
                present_next[req_reg.task_id] = 1'b0;
                if (count_reg == CW'(1)) begin
                    state_next = imhs_pkg::S_FIN;
                end else begin
                    heap_re    = 1'b1;
                    heap_raddr = SW'(count_reg - CW'(1));
                    state_next = imhs_pkg::S_RM_LD;
                end
            end
            imhs_pkg::S_RM_LD: begin
                cur_next   = heap_rd_reg;
                s_next     = '0;
                state_next = imhs_pkg::S_DN;
            end
            imhs_pkg::S_DN: begin
                if (left_x >= n_x) begin
                    heap_we = 1'b1;
                    pos_we  = 1'b1;
                    state_next = imhs_pkg::S_FIN;
                end else begin
                    heap_re    = 1'b1;
                    heap_raddr = left_x[SW-1:0];
                    state_next = imhs_pkg::S_DN_L;
                end
            end
            imhs_pkg::S_DN_L: begin
                bwin_next = heap_rd_reg.prio < cur_reg.prio;
                best_next = (heap_rd_reg.prio < cur_reg.prio) ? heap_rd_reg : cur_reg;
                bidx_next = left_x[SW-1:0];
                if (right_x < n_x) begin
                    heap_re    = 1'b1;
                    heap_raddr = right_x[SW-1:0];
                    state_next = imhs_pkg::S_DN_R;
                end else begin
                    state_next = imhs_pkg::S_DN_DEC;
                end
            end
            imhs_pkg::S_DN_R: begin
                if (heap_rd_reg.prio < best_reg.prio) begin
                    bwin_next = 1'b1;
                    best_next = heap_rd_reg;
                    bidx_next = right_x[SW-1:0];
                end
                state_next = imhs_pkg::S_DN_DEC;
            end
            imhs_pkg::S_DN_DEC: begin
                heap_we = 1'b1;
                pos_we  = 1'b1;
                if (bwin_reg) begin
                    // winning child moves up into the hole
                    heap_wdata = best_reg;
                    pos_waddr  = best_reg.task_id;
                    s_next     = bidx_reg;
                    state_next = imhs_pkg::S_DN;
                end else begin
                    state_next = imhs_pkg::S_FIN;
                end
            end
            imhs_pkg::S_FIN: begin
                heap_re    = 1'b1;
                heap_raddr = '0;
                state_next = imhs_pkg::S_FIN2;
            end
            imhs_pkg::S_FIN2: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next.entry_count = 5'(count_reg);
                    m_data_next.status      = stat_reg;
                    if (count_reg == '0) begin
                        m_data_next.top_task     = '0;
                        m_data_next.top_priority = '0;
                        m_data_next.heap_empty   = 1'b1;
                    end else begin
                        m_data_next.top_task     = heap_rd_reg.task_id;
                        m_data_next.top_priority = heap_rd_reg.prio;
                        m_data_next.heap_empty   = 1'b0;
                    end
                    state_next = imhs_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = imhs_pkg::S_IDLE;
            end
        endcase
    end

endmodule
